### rtl/core/mts_pkg.sv
package mts_pkg;

  localparam int MONTH_W     = 4;
  localparam int TEMP_W      = 8;
  localparam int FRAC_BITS   = 4;
  localparam int AVG_W       = 12;
  localparam int COUNT_OUT_W = 16;
  // quotient bits: |mean| * 16 never exceeds 128 * 16
  localparam int QUO_BITS    = TEMP_W + FRAC_BITS;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_REPORT = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } mts_div_stat_t;

endpackage

### rtl/core/mts_in_if.sv
interface mts_in_if
  import mts_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [MONTH_W-1:0]       month;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, action, month, temperature, input ready);
  modport sink   (input valid, action, month, temperature, output ready);
endinterface

### rtl/core/mts_out_if.sv
interface mts_out_if
  import mts_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [MONTH_W-1:0]       scope;
  logic                     has_data;
  logic [COUNT_OUT_W-1:0]   sample_count;
  logic signed [AVG_W-1:0]  average;
  logic signed [TEMP_W-1:0] maximum;
  logic signed [TEMP_W-1:0] minimum;

  modport source (output valid, scope, has_data, sample_count, average, maximum, minimum,
                  input ready);
  modport sink   (input valid, scope, has_data, sample_count, average, maximum, minimum,
                  output ready);
endinterface

### rtl/core/mts_ram.sv
module mts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/mts_div.sv
module mts_div
  import mts_pkg::*;
#(
  parameter int CNT_W = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       neg,
  input  logic [CNT_W+TEMP_W-1:0]    mag,
  input  logic [CNT_W-1:0]           divisor,
  output mts_div_stat_t              stat,
  output logic signed [AVG_W-1:0]    avg
);

  localparam int STEP_W = $clog2(QUO_BITS + 1);

  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [QUO_BITS-1:0] low_r, low_nxt;
  logic [CNT_W-1:0]    div_r;
  logic                neg_r;
  logic [STEP_W-1:0]   step_r;
  logic                busy_r, done_r;
  logic [CNT_W:0]      trial, diff;
  logic                ge;
  logic [QUO_BITS-1:0] quo_neg;

  // one quotient bit per cycle; the low word shifts out dividend bits and in quotient bits
  assign trial = {rem_r, low_r[QUO_BITS-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    low_nxt = {low_r[QUO_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(QUO_BITS);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // |sum| * 16: top part is below the divisor, so only QUO_BITS steps remain
      rem_r <= mag[CNT_W+TEMP_W-1:TEMP_W];
      low_r <= {mag[TEMP_W-1:0], {FRAC_BITS{1'b0}}};
      div_r <= divisor;
      neg_r <= neg;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign quo_neg   = -low_r;
  assign avg       = neg_r ? $signed(quo_neg[AVG_W-1:0]) : $signed(low_r[AVG_W-1:0]);
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

### rtl/core/monthly_temperature_statistics.sv
// Monthly temperature statistics.
// in_ch (sink): valid/ready with action, month, temperature. Action add folds a
// sample into the year totals and, for month 1..MONTH_BINS, into that month's
// bin. Action report returns one transaction on out_ch for month 0 (year) or a
// month in range; other months give nothing. Action clear empties everything.
// out_ch (source): valid/ready with scope, has_data, sample_count, average
// (Q.4, truncated toward zero), maximum and minimum.
// Sequencing: clear, an add outside the month range, a dropped report and code 3
// finish on acceptance. An add does one synchronous read of the bin memory,
// then the write back. A report fetches the scope (a bin read for a month),
// then runs the serial divider (skipped when the scope is empty), then loads
// the output register, which drives out_ch.valid.
// One transaction is in work at a time; in_ch.ready is high while idle.
// When out_ch stalls, a pending result holds in the output register and the
// block keeps taking adds and clears; a second report waits until the first
// result is taken.
// Reset clears all bin valid flags, the year totals and the output valid;
// there is no clearing pass, an unwritten bin reads as empty.
module monthly_temperature_statistics
  import mts_pkg::*;
#(
  parameter int MONTH_BINS = 12,
  parameter int COUNT_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  mts_in_if.sink   in_ch,
  mts_out_if.source out_ch
);

  localparam int SUM_W = COUNT_BITS + TEMP_W;
  localparam int BIN_W = MONTH_BINS > 1 ? $clog2(MONTH_BINS) : 1;
  localparam logic [COUNT_BITS-1:0] CNT_FULL = '1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic [COUNT_BITS-1:0]    cnt;
    logic signed [TEMP_W-1:0] mx;
    logic signed [TEMP_W-1:0] mn;
  } stats_t;

  function automatic stats_t accum(input stats_t s, input logic signed [TEMP_W-1:0] t);
    stats_t r;
    r = s;
    if (s.cnt != CNT_FULL) begin
      if (s.cnt == '0) begin
        r.mx = t;
        r.mn = t;
      end else begin
        if (t > s.mx) r.mx = t;
        if (t < s.mn) r.mn = t;
      end
      r.sum = s.sum + SUM_W'(t);
      r.cnt = s.cnt + 1'b1;
    end
    return r;
  endfunction

  logic [2:0]               state_r, state_nxt;
  logic [1:0]               act_r;
  logic [BIN_W-1:0]         idx_r;
  logic [MONTH_W-1:0]       scope_r;
  logic signed [TEMP_W-1:0] temp_r;
  logic [MONTH_BINS-1:0]    bin_vld_r;
  logic                     rd_vld_r;
  stats_t                   year_r;
  stats_t                   snap_r;
  stats_t                   bin_rd, bin_new;
  logic [$bits(stats_t)-1:0] ram_rdata;

  logic                     in_acc, in_rng;
  logic [MONTH_W-1:0]       mon_m1;
  logic [BIN_W-1:0]         in_idx;

  logic                     out_valid_r;
  logic [MONTH_W-1:0]       out_scope_r;
  logic                     out_has_r;
  logic [COUNT_OUT_W-1:0]   out_cnt_r;
  logic signed [AVG_W-1:0]  out_avg_r;
  logic signed [TEMP_W-1:0] out_max_r, out_min_r;
  logic                     out_load;

  logic                     sum_neg;
  logic [SUM_W-1:0]         sum_neg_v, sum_mag;
  logic                     div_start;
  mts_div_stat_t            div_stat;
  logic signed [AVG_W-1:0]  div_avg;
  logic                     snap_has;

  assign in_ch.ready = state_r == ST_IDLE;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign mon_m1      = in_ch.month - 4'd1;
  assign in_idx      = mon_m1[BIN_W-1:0];
  assign in_rng      = (in_ch.month != '0) &&
                       ({1'b0, in_ch.month} <= (MONTH_W+1)'(MONTH_BINS));

  // empty bins read as zero until first written
  assign bin_rd  = rd_vld_r ? stats_t'(ram_rdata) : '0;
  assign bin_new = accum(bin_rd, temp_r);

  mts_ram #(
    .WIDTH ($bits(stats_t)),
    .DEPTH (MONTH_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (state_r == ST_READ && act_r == ACT_ADD),
    .waddr (idx_r),
    .wdata (bin_new),
    .re    (in_acc),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  assign snap_has  = snap_r.cnt != '0;
  assign sum_neg   = snap_r.sum[SUM_W-1];
  assign sum_neg_v = -snap_r.sum;
  assign sum_mag   = sum_neg ? sum_neg_v : snap_r.sum;
  assign div_start = state_r == ST_START && snap_has;

  mts_div #(
    .CNT_W (COUNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .neg     (sum_neg),
    .mag     (sum_mag),
    .divisor (snap_r.cnt),
    .stat    (div_stat),
    .avg     (div_avg)
  );

  assign out_load = state_r == ST_OUT && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_ADD && in_rng) begin
            state_nxt = ST_READ;
          end else if (in_ch.action == ACT_REPORT) begin
            if (in_ch.month == '0) state_nxt = ST_START;
            else if (in_rng) state_nxt = ST_READ;
          end
        end
      end
      ST_READ:  state_nxt = act_r == ACT_ADD ? ST_IDLE : ST_START;
      ST_START: state_nxt = snap_has ? ST_DIV : ST_OUT;
      ST_DIV:   if (div_stat.done) state_nxt = ST_OUT;
      ST_OUT:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bin_vld_r   <= '0;
      year_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_ch.action == ACT_CLEAR) begin
        bin_vld_r <= '0;
        year_r    <= '0;
      end else if (in_acc && in_ch.action == ACT_ADD) begin
        year_r <= accum(year_r, in_ch.temperature);
      end
      if (state_r == ST_READ && act_r == ACT_ADD) begin
        bin_vld_r[idx_r] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_ch.action;
      idx_r    <= in_idx;
      scope_r  <= in_ch.month;
      temp_r   <= in_ch.temperature;
      rd_vld_r <= bin_vld_r[in_idx];
      snap_r   <= year_r;
    end
    if (state_r == ST_READ) begin
      snap_r <= bin_rd;
    end
    if (out_load) begin
      out_scope_r <= scope_r;
      out_has_r   <= snap_has;
      out_cnt_r   <= COUNT_OUT_W'(snap_r.cnt);
      out_avg_r   <= snap_has ? div_avg : '0;
      out_max_r   <= snap_has ? snap_r.mx : '0;
      out_min_r   <= snap_has ? snap_r.mn : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.scope        = out_scope_r;
  assign out_ch.has_data     = out_has_r;
  assign out_ch.sample_count = out_cnt_r;
  assign out_ch.average      = out_avg_r;
  assign out_ch.maximum      = out_max_r;
  assign out_ch.minimum      = out_min_r;

endmodule

### rtl/core/mts_chk.sv
module mts_chk
  import mts_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     has_data,
  input logic signed [AVG_W-1:0]  average,
  input logic signed [TEMP_W-1:0] maximum,
  input logic signed [TEMP_W-1:0] minimum
);

  // a result never survives reset
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // empty scope reports zeros
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_data |-> average == '0 && maximum == '0 && minimum == '0)
    else $error("empty scope with nonzero statistics");

  // mean lies between the extremes
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && has_data |->
      minimum <= maximum &&
      (average >>> FRAC_BITS) <= AVG_W'(maximum) &&
      average >= (AVG_W'(minimum) <<< FRAC_BITS) - AVG_W'(FRAC_BITS'(0)))
    else $error("statistics out of order");

endmodule

bind monthly_temperature_statistics mts_chk u_mts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .has_data  (out_ch.has_data),
  .average   (out_ch.average),
  .maximum   (out_ch.maximum),
  .minimum   (out_ch.minimum)
);

### bench/monthly_temperature_statistics_test.sv
module monthly_temperature_statistics_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mts_pkg::*;

  localparam int          MONTHS     = 12;
  localparam int unsigned COUNT_FULL = 32'd65535;
  localparam int          HOLD_LEN   = 400;
  localparam int          DRAIN_LEN  = 40;
  localparam logic [1:0]  ACT_SPARE  = 2'd3;

  typedef struct {
    logic [1:0]               action;
    logic [MONTH_W-1:0]       month;
    logic signed [TEMP_W-1:0] temperature;
  } reading_t;

  typedef struct {
    logic [MONTH_W-1:0]       scope;
    logic                     has_data;
    logic [COUNT_OUT_W-1:0]   sample_count;
    logic signed [AVG_W-1:0]  average;
    logic signed [TEMP_W-1:0] maximum;
    logic signed [TEMP_W-1:0] minimum;
  } report_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  mts_in_if  in_ch ();
  mts_out_if out_ch ();

  monthly_temperature_statistics #(
    .MONTH_BINS(MONTHS),
    .COUNT_BITS(16)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // slot 0 is the whole year, slots 1..MONTHS the months
  longint      tally_sum   [0:MONTHS];
  int unsigned tally_count [0:MONTHS];
  int          tally_max   [0:MONTHS];
  int          tally_min   [0:MONTHS];

  reading_t pending_readings[$];
  report_t  expected_reports[$];

  int   mismatches      = 0;
  int   readings_taken  = 0;
  int   reports_checked = 0;
  logic in_taken        = 1'b0;
  logic no_idle         = 1'b0;
  logic hold_request    = 1'b0;
  logic hold_done       = 1'b0;
  int   hold_left       = 0;
  reading_t next_reading;

  function automatic void clear_tallies();
    for (int i = 0; i <= MONTHS; i++) begin
      tally_sum[i]   = 0;
      tally_count[i] = 0;
      tally_max[i]   = 0;
      tally_min[i]   = 0;
    end
  endfunction

  function automatic void fold(int slot, int t);
    if (tally_count[slot] >= COUNT_FULL) return;
    if (tally_count[slot] == 0) begin
      tally_max[slot] = t;
      tally_min[slot] = t;
    end else begin
      if (t > tally_max[slot]) tally_max[slot] = t;
      if (t < tally_min[slot]) tally_min[slot] = t;
    end
    tally_sum[slot]   += t;
    tally_count[slot] += 1;
  endfunction

  function automatic void apply_reading(reading_t r);
    int      t;
    int      slot;
    longint  mean_q4;
    report_t rep;
    t = r.temperature;
    case (r.action)
      ACT_ADD: begin
        fold(0, t);
        if (r.month >= 1 && r.month <= MONTHS) fold(int'(r.month), t);
      end
      ACT_REPORT: begin
        if (r.month <= MONTHS) begin
          slot             = r.month;
          rep.scope        = r.month;
          rep.has_data     = tally_count[slot] != 0;
          rep.sample_count = tally_count[slot][15:0];
          mean_q4          = 0;
          if (rep.has_data) begin
            mean_q4 = (tally_sum[slot] * 16) / longint'(tally_count[slot]);
          end
          rep.average = mean_q4[AVG_W-1:0];
          rep.maximum = rep.has_data ? TEMP_W'(tally_max[slot]) : '0;
          rep.minimum = rep.has_data ? TEMP_W'(tally_min[slot]) : '0;
          expected_reports.push_back(rep);
        end
      end
      ACT_CLEAR: clear_tallies();
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(string field, int got, int want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    end
  endtask

  task automatic queue_reading(logic [1:0] action, int month, int temp);
    reading_t r;
    r.action      = action;
    r.month       = MONTH_W'(month);
    r.temperature = TEMP_W'(temp);
    pending_readings.push_back(r);
  endtask

  function automatic int random_temp();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 127 : -128;
    return int'($signed(8'($urandom_range(255))));
  endfunction

  // mostly in-range adds and reports, with clears, stray months and the spare code
  task automatic queue_random(int n);
    int counted;
    int roll;
    counted = 0;
    while (counted < n) begin
      roll = $urandom_range(99);
      counted++;
      if (roll < 55) begin
        queue_reading(ACT_ADD, $urandom_range(1, MONTHS), random_temp());
      end else if (roll < 62) begin
        queue_reading(ACT_ADD, ($urandom_range(1) != 0) ? $urandom_range(13, 15) : 0,
                      random_temp());
      end else if (roll < 85) begin
        queue_reading(ACT_REPORT, $urandom_range(0, MONTHS), random_temp());
      end else if (roll < 89) begin
        queue_reading(ACT_REPORT, $urandom_range(13, 15), random_temp());
      end else if (roll < 91) begin
        queue_reading(ACT_CLEAR, $urandom_range(15), random_temp());
      end else if (roll < 94) begin
        queue_reading(ACT_SPARE, $urandom_range(15), random_temp());
        counted--;
      end else begin
        queue_reading(ACT_ADD, $urandom_range(15), random_temp());
      end
    end
  endtask

  function automatic bit quiet();
    return pending_readings.size() == 0 && !in_ch.valid && expected_reports.size() == 0;
  endfunction

  task automatic wait_quiet();
    while (!quiet()) @(posedge clk);
  endtask

  // driver: hold the offered transaction until taken, then advance
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (pending_readings.size() != 0 && (no_idle || $urandom_range(99) >= 10)) begin
        next_reading = pending_readings.pop_front();
        in_ch.action      <= next_reading.action;
        in_ch.month       <= next_reading.month;
        in_ch.temperature <= next_reading.temperature;
        in_ch.valid       <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side ready, with one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_LEN;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 10;
    end
  end

  always @(posedge clk) begin : monitor
    report_t  got;
    report_t  want;
    reading_t seen;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.scope        = out_ch.scope;
        got.has_data     = out_ch.has_data;
        got.sample_count = out_ch.sample_count;
        got.average      = out_ch.average;
        got.maximum      = out_ch.maximum;
        got.minimum      = out_ch.minimum;
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected report, scope", got.scope, -1);
        end else begin
          want = expected_reports.pop_front();
          reports_checked++;
          if (got.scope !== want.scope) flag_mismatch("scope", got.scope, want.scope);
          if (got.has_data !== want.has_data) begin
            flag_mismatch("has_data", got.has_data, want.has_data);
          end
          if (got.sample_count !== want.sample_count) begin
            flag_mismatch("sample_count", got.sample_count, want.sample_count);
          end
          if (got.average !== want.average) begin
            flag_mismatch("average", got.average, want.average);
          end
          if (got.maximum !== want.maximum) begin
            flag_mismatch("maximum", got.maximum, want.maximum);
          end
          if (got.minimum !== want.minimum) begin
            flag_mismatch("minimum", got.minimum, want.minimum);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.action      = in_ch.action;
        seen.month       = in_ch.month;
        seen.temperature = in_ch.temperature;
        readings_taken++;
        apply_reading(seen);
      end
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.action      = ACT_ADD;
    in_ch.month       = '0;
    in_ch.temperature = '0;
    out_ch.ready      = 1'b0;
    clear_tallies();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty scopes, out-of-range reports, extremes, stray months, spare code
    queue_reading(ACT_REPORT, 0, 0);
    queue_reading(ACT_REPORT, 1, 0);
    queue_reading(ACT_REPORT, MONTHS, 0);
    queue_reading(ACT_REPORT, 13, 0);
    queue_reading(ACT_REPORT, 15, 0);
    queue_reading(ACT_ADD, 1, 127);
    queue_reading(ACT_ADD, 1, -128);
    queue_reading(ACT_ADD, MONTHS, 0);
    queue_reading(ACT_ADD, 0, -1);
    queue_reading(ACT_ADD, 13, 5);
    queue_reading(ACT_ADD, 15, -77);
    queue_reading(ACT_SPARE, 15, -1);
    queue_reading(ACT_REPORT, 0, 0);
    queue_reading(ACT_REPORT, 1, 0);
    queue_reading(ACT_REPORT, MONTHS, 0);
    queue_reading(ACT_REPORT, 14, 0);
    // negative mean that truncates toward zero
    queue_reading(ACT_ADD, 3, -1);
    queue_reading(ACT_ADD, 3, -1);
    queue_reading(ACT_ADD, 3, 0);
    queue_reading(ACT_REPORT, 3, 0);
    queue_reading(ACT_CLEAR, 7, 33);
    queue_reading(ACT_REPORT, 0, 0);
    queue_reading(ACT_REPORT, 1, 0);
    wait_quiet();

    // fill the result side while it holds off
    queue_random(650);
    @(posedge clk);
    hold_request = 1'b1;
    wait_quiet();

    @(posedge clk);
    no_idle = 1'b1;
    queue_random(300);
    wait_quiet();
    @(posedge clk);
    no_idle = 1'b0;

    queue_random(550);
    wait_quiet();
    repeat (DRAIN_LEN) @(posedge clk);

    $display("Run covered %0d input transactions and %0d checked reports:", readings_taken,
             reports_checked);
    $display("corner cases, random mixes, a long output hold-off and a gap-free stretch.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### monthly_temperature_statistics.f
rtl/core/mts_pkg.sv
rtl/core/mts_in_if.sv
rtl/core/mts_out_if.sv
rtl/core/mts_ram.sv
rtl/core/mts_div.sv
rtl/core/monthly_temperature_statistics.sv
rtl/core/mts_chk.sv
bench/monthly_temperature_statistics_test.sv
